/* hdl/bilateral_filter_window_assert.svh */
// assertion macros for the bilateral filter window block
`ifndef BILATERAL_FILTER_WINDOW_ASSERT_SVH
`define BILATERAL_FILTER_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
`define BFW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BFW_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BFW_ASSERT(lbl, clk, rstn, prop, msg)
`define BFW_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* hdl/bfw_pkg.sv */
// shared types and constants of the bilateral filter window block
`default_nettype none
package bfw_pkg;
    localparam int PIX_W       = 8;
    localparam int TIDX_W      = 8;
    localparam int TVAL_W      = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int MAX_HEIGHT  = 1024;
    localparam int ROW_W       = 10;
    localparam int CFG_W       = 11;
    localparam int RAD_W       = 3;
    localparam int SPATIAL_DEPTH = 64;
    localparam int SIDX_W      = 6;
    localparam int RANGE_DEPTH = 256;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef enum logic [1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_FLUSH   = 2'd1,
        CMD_SPATIAL = 2'd2,
        CMD_RANGE   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               kind;
        logic [PIX_W-1:0]   pixel;
        logic [TIDX_W-1:0]  index;
        logic [TVAL_W-1:0]  value;
    } bfw_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [RAD_W-1:0] window_radius;
    } bfw_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_E0,
        ST_E1,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } bfw_state_t;
endpackage
`default_nettype wire

/* hdl/bfw_front.sv */
// input side: accepts items, drops out-of-range spatial writes, two-entry queue
`default_nettype none
module bfw_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [bfw_pkg::PIX_W-1:0]  pixel_value,
    input  wire logic [bfw_pkg::TIDX_W-1:0] table_index,
    input  wire logic [bfw_pkg::TVAL_W-1:0] table_value,
    output logic                            q_valid,
    output bfw_pkg::bfw_item_t              q_item,
    input  wire logic                       q_take
);
    bfw_pkg::bfw_item_t fifo_mem [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       accept, keep, push;
    bfw_pkg::bfw_item_t item;

    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item.kind  = bfw_pkg::cmd_t'(cmd);
        item.pixel = pixel_value;
        item.index = table_index;
        item.value = table_value;
        // spatial entries above the table are ignored
        keep = !((item.kind == bfw_pkg::CMD_SPATIAL) &&
                 (table_index >= bfw_pkg::TIDX_W'(bfw_pkg::SPATIAL_DEPTH)));
    end

    assign push    = accept && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_take)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wptr_reg] <= item;
        end
    end
endmodule
`default_nettype wire

/* hdl/bfw_back.sv */
// execution side: line store, weight tables, window accumulation and divide
`default_nettype none
`include "bilateral_filter_window_assert.svh"
module bfw_back
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bfw_pkg::bfw_cfg_t          cfg,
    input  wire logic                       q_valid,
    input  wire bfw_pkg::bfw_item_t         q_item,
    output logic                            q_take,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [bfw_pkg::PIX_W-1:0]       filtered_pixel,
    output logic                            last_of_frame
);
    localparam int DEPTH   = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int PW      = $clog2(LAG_MAX + 2);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int DW      = RW + 1;
    localparam int OW      = $clog2(LAG_MAX + 1) + 1;
    localparam int NWIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int KW      = $clog2(NWIN) + bfw_pkg::TVAL_W;
    localparam int FW      = KW + bfw_pkg::PIX_W;
    localparam int HW      = bfw_pkg::CFG_W;
    localparam int PXW     = bfw_pkg::PIX_W;

    // memories
    logic [PXW-1:0]                line_store [DEPTH];
    logic [bfw_pkg::TVAL_W-1:0]    spatial_mem [bfw_pkg::SPATIAL_DEPTH];
    logic [bfw_pkg::TVAL_W-1:0]    range_mem [bfw_pkg::RANGE_DEPTH];
    logic [PXW-1:0]                ls_q;
    logic [bfw_pkg::TVAL_W-1:0]    sp_q, rw_q;

    bfw_pkg::bfw_state_t state_reg, state_next;

    // control state
    logic [AW-1:0]  wr_addr_reg;
    logic [PW-1:0]  pending_reg;
    logic [bfw_pkg::ROW_W-1:0] out_row_reg;
    logic [CW-1:0]  out_col_reg;
    logic           out_valid_reg;
    logic [1:0]     drain_cnt_reg;
    logic           s1_v_reg, s2_v_reg, s3_v_reg;

    // payload
    logic [PW-1:0]  span_reg;
    logic [AW-1:0]  pos_reg, row_addr_reg, cur_addr_reg;
    logic signed [OW-1:0] row_off_reg, cur_off_reg;
    logic signed [DW-1:0] dy_reg, dx_reg;
    logic [PXW-1:0] centre_reg;
    logic [SW_DUMMY_W-1:0] unused_never;
    localparam int SW_DUMMY_W = 1;
    logic [bfw_pkg::SIDX_W-1:0] s1_sidx_reg;
    logic [PXW-1:0] s2_p_reg, s3_p_reg;
    logic [2*bfw_pkg::TVAL_W-1:0] s3_prod_reg;
    logic [FW-1:0]  f_reg, rem_reg;
    logic [KW-1:0]  k_reg;
    logic [2:0]     div_bit_reg;
    logic [PXW-1:0] quot_reg;
    logic [PXW-1:0] pix_out_reg;
    logic           last_out_reg;

    // effective geometry
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [RW-1:0]  r_eff;
    logic signed [DW-1:0] r_s;

    always_comb
    begin
        if (cfg.frame_width == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(cfg.frame_width);
        end
        if (cfg.frame_height == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(cfg.frame_height) > 32'(bfw_pkg::MAX_HEIGHT))
        begin
            h_eff = HW'(bfw_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = cfg.frame_height;
        end
        if (32'(cfg.window_radius) > 32'(MAX_RADIUS))
        begin
            r_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RW'(cfg.window_radius);
        end
        r_s = DW'(r_eff);
    end

    assign unused_never = 1'b0;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (s[AW])
        begin
            s = s + (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // window walk control
    logic dx_last, dy_last, nb_ok, out_load, issue;
    logic [AW-1:0] pos_next, rd_addr, w_addr;
    logic [bfw_pkg::SIDX_W-1:0] sidx;
    logic [PXW-1:0] diff;
    logic [bfw_pkg::TVAL_W-1:0] wt;
    logic [PXW+bfw_pkg::TVAL_W-1:0] pw_prod;
    logic [FW-1:0] trial;
    logic col_end, row_end;

    assign dx_last  = (dx_reg == r_s);
    assign dy_last  = (dy_reg == r_s);
    assign pos_next = wrap_sub(wr_addr_reg, AW'(pending_reg));
    assign w_addr   = AW'(w_eff);

    always_comb
    begin
        int rr, cc, ady, adx;
        rr  = int'(out_row_reg) + int'(dy_reg);
        cc  = int'(out_col_reg) + int'(dx_reg);
        ady = (dy_reg < 0) ? -int'(dy_reg) : int'(dy_reg);
        adx = (dx_reg < 0) ? -int'(dx_reg) : int'(dx_reg);
        nb_ok = (rr >= 0) && (rr < int'(h_eff)) && (cc >= 0) && (cc < int'(w_eff)) &&
                (int'(cur_off_reg) < int'(pending_reg));
        sidx  = bfw_pkg::SIDX_W'(ady * 8 + adx);
    end

    assign diff    = (ls_q > centre_reg) ? (ls_q - centre_reg) : (centre_reg - ls_q);
    assign wt      = s3_prod_reg[bfw_pkg::WEIGHT_BITS +: bfw_pkg::TVAL_W];
    assign pw_prod = (PXW+bfw_pkg::TVAL_W)'(s3_p_reg) * (PXW+bfw_pkg::TVAL_W)'(wt);
    assign trial   = FW'(k_reg) << div_bit_reg;
    assign col_end = (32'(out_col_reg) + 32'd1) >= 32'(w_eff);
    assign row_end = (32'(out_row_reg) + 32'd1) >= 32'(h_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfw_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        bfw_pkg::CMD_PIXEL: state_next = bfw_pkg::ST_CHK;
                        bfw_pkg::CMD_FLUSH:
                        begin
                            if (pending_reg != '0)
                            begin
                                state_next = bfw_pkg::ST_E0;
                            end
                        end
                        default: state_next = bfw_pkg::ST_IDLE;
                    endcase
                end
            end
            bfw_pkg::ST_CHK:
            begin
                state_next = (pending_reg > span_reg) ? bfw_pkg::ST_E0 : bfw_pkg::ST_IDLE;
            end
            bfw_pkg::ST_E0: state_next = bfw_pkg::ST_E1;
            bfw_pkg::ST_E1: state_next = bfw_pkg::ST_RUN;
            bfw_pkg::ST_RUN:
            begin
                if (dx_last && dy_last)
                begin
                    state_next = bfw_pkg::ST_DRAIN;
                end
            end
            bfw_pkg::ST_DRAIN:
            begin
                if (drain_cnt_reg == 2'd3)
                begin
                    state_next = bfw_pkg::ST_DIV;
                end
            end
            bfw_pkg::ST_DIV:
            begin
                if (div_bit_reg == 3'd0)
                begin
                    state_next = bfw_pkg::ST_OUT;
                end
            end
            bfw_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = bfw_pkg::ST_IDLE;
                end
            end
            default: state_next = bfw_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_take   = 1'b0;
        out_load = 1'b0;
        issue    = 1'b0;
        rd_addr  = cur_addr_reg;
        case (state_reg)
            bfw_pkg::ST_IDLE: q_take = q_valid;
            bfw_pkg::ST_E0:   rd_addr = pos_next;
            bfw_pkg::ST_RUN:  issue = 1'b1;
            bfw_pkg::ST_OUT:  out_load = !out_valid_reg || !out_stall;
            default:          q_take = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (q_take && (q_item.kind == bfw_pkg::CMD_PIXEL))
        begin
            line_store[wr_addr_reg] <= q_item.pixel;
        end
        ls_q <= line_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_take && (q_item.kind == bfw_pkg::CMD_SPATIAL))
        begin
            spatial_mem[q_item.index[bfw_pkg::SIDX_W-1:0]] <= q_item.value;
        end
        sp_q <= spatial_mem[s1_sidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_take && (q_item.kind == bfw_pkg::CMD_RANGE))
        begin
            range_mem[q_item.index] <= q_item.value;
        end
        rw_q <= range_mem[diff];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfw_pkg::ST_IDLE;
            wr_addr_reg   <= '0;
            pending_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_valid_reg <= 1'b0;
            drain_cnt_reg <= 2'd0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= issue && nb_ok;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            if (q_take && (q_item.kind == bfw_pkg::CMD_PIXEL))
            begin
                wr_addr_reg <= wrap_add(wr_addr_reg, AW'(1));
                pending_reg <= pending_reg + PW'(1);
            end
            if (state_reg == bfw_pkg::ST_DRAIN)
            begin
                drain_cnt_reg <= drain_cnt_reg + 2'd1;
            end
            else
            begin
                drain_cnt_reg <= 2'd0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= pending_reg - PW'(1);
                if (col_end)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= row_end ? '0 : out_row_reg + bfw_pkg::ROW_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        span_reg    <= PW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
        s1_sidx_reg <= sidx;
        s2_p_reg    <= ls_q;
        s3_p_reg    <= s2_p_reg;
        s3_prod_reg <= (2*bfw_pkg::TVAL_W)'(sp_q) * (2*bfw_pkg::TVAL_W)'(rw_q);
        if (s3_v_reg)
        begin
            f_reg <= f_reg + FW'(pw_prod);
            k_reg <= k_reg + KW'(wt);
        end
        case (state_reg)
            bfw_pkg::ST_E0:
            begin
                pos_reg <= pos_next;
            end
            bfw_pkg::ST_E1:
            begin
                centre_reg   <= ls_q;
                row_addr_reg <= wrap_sub(pos_reg, AW'(span_reg));
                cur_addr_reg <= wrap_sub(pos_reg, AW'(span_reg));
                row_off_reg  <= -$signed(OW'(span_reg));
                cur_off_reg  <= -$signed(OW'(span_reg));
                dy_reg       <= -r_s;
                dx_reg       <= -r_s;
                f_reg        <= '0;
                k_reg        <= '0;
            end
            bfw_pkg::ST_RUN:
            begin
                if (dx_last)
                begin
                    dy_reg       <= dy_reg + DW'(1);
                    dx_reg       <= -r_s;
                    row_addr_reg <= wrap_add(row_addr_reg, w_addr);
                    cur_addr_reg <= wrap_add(row_addr_reg, w_addr);
                    row_off_reg  <= row_off_reg + $signed(OW'(w_eff));
                    cur_off_reg  <= row_off_reg + $signed(OW'(w_eff));
                end
                else
                begin
                    dx_reg       <= dx_reg + DW'(1);
                    cur_addr_reg <= wrap_add(cur_addr_reg, AW'(1));
                    cur_off_reg  <= cur_off_reg + OW'(1);
                end
            end
            bfw_pkg::ST_DRAIN:
            begin
                rem_reg     <= f_reg;
                quot_reg    <= '0;
                div_bit_reg <= 3'd7;
            end
            bfw_pkg::ST_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg               <= rem_reg - trial;
                    quot_reg[div_bit_reg] <= 1'b1;
                end
                div_bit_reg <= div_bit_reg - 3'd1;
            end
            bfw_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    pix_out_reg  <= (k_reg == '0) ? centre_reg : quot_reg;
                    last_out_reg <= col_end && row_end;
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = pix_out_reg;
    assign last_of_frame  = last_out_reg | unused_never[0];

    `BFW_ASSERT(a_take_idle, clk, rst_n, q_take |-> state_reg == bfw_pkg::ST_IDLE, "pop outside idle")
    `BFW_ASSERT(a_pending_max, clk, rst_n, 32'(pending_reg) <= 32'(LAG_MAX + 1), "pending overflow")
    `BFW_ASSERT(a_out_dec, clk, rst_n, out_load |=> pending_reg + PW'(1) == $past(pending_reg), "pending not decremented on output")
    `BFW_NEVER(a_div_drained, clk, rst_n, (state_reg == bfw_pkg::ST_DIV) && (s1_v_reg || s2_v_reg || s3_v_reg), "divide before window drained")
endmodule
`default_nettype wire

/* hdl/bilateral_filter_window.sv */
// top level: bilateral filter over a grayscale raster stream
// a pixel releases an output once the line store holds its whole window; items that
// release nothing are table writes, early pixels and flushes with nothing pending
// throughput: one window neighbour per cycle, set by the single line store read port
// reset: rst_n asynchronous active low clears counters, queue and valids; geometry
// registers return to 512 x 424 with radius 7; line store and weight tables are not cleared
`default_nettype none
module bilateral_filter_window
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bfw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bfw_pkg::PDATA_W-1:0]  pwdata,
    output logic [bfw_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // input transfer
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   cmd,
    input  wire logic [bfw_pkg::PIX_W-1:0]    pixel_value,
    input  wire logic [bfw_pkg::TIDX_W-1:0]   table_index,
    input  wire logic [bfw_pkg::TVAL_W-1:0]   table_value,
    // output transfer
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [bfw_pkg::PIX_W-1:0]         filtered_pixel,
    output logic                              last_of_frame
);
    bfw_pkg::bfw_cfg_t  cfg_reg;
    bfw_pkg::bfw_item_t q_item;
    logic               q_valid, q_take;
    logic               cfg_wr;
    logic [1:0]         reg_sel;

    // configuration registers, written on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= bfw_pkg::CFG_W'(512);
            cfg_reg.frame_height  <= bfw_pkg::CFG_W'(424);
            cfg_reg.window_radius <= bfw_pkg::RAD_W'(7);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                bfw_pkg::REG_FRAME_WIDTH:   cfg_reg.frame_width   <= pwdata[bfw_pkg::CFG_W-1:0];
                bfw_pkg::REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= pwdata[bfw_pkg::CFG_W-1:0];
                bfw_pkg::REG_WINDOW_RADIUS: cfg_reg.window_radius <= pwdata[bfw_pkg::RAD_W-1:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        case (reg_sel)
            bfw_pkg::REG_FRAME_WIDTH:   prdata = bfw_pkg::PDATA_W'(cfg_reg.frame_width);
            bfw_pkg::REG_FRAME_HEIGHT:  prdata = bfw_pkg::PDATA_W'(cfg_reg.frame_height);
            bfw_pkg::REG_WINDOW_RADIUS: prdata = bfw_pkg::PDATA_W'(cfg_reg.window_radius);
            default:                    prdata = '0;
        endcase
    end

    // front: takes each transfer while not stalled, queues all but out-of-range spatial writes
    bfw_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pixel_value (pixel_value),
        .table_index (table_index),
        .table_value (table_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take)
    );

    // back: line store, window walk, weighting and divide
    bfw_back
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_take         (q_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_pixel (filtered_pixel),
        .last_of_frame  (last_of_frame)
    );
endmodule
`default_nettype wire
